/* hw/rtl/bdlp_pkg.sv */
// Shared types and constants for the button debouncer with long press detection.
// Used by bdlp_debounce, bdlp_hold and button_debounce_long_press.
`default_nettype none
package bdlp_pkg;

    localparam int SETTLE_COUNT_BITS_DEF = 16;
    localparam int HOLD_COUNT_BITS_DEF   = 24;

    localparam int DEBOUNCE_W   = 16;
    localparam int HOLD_TICKS_W = 24;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int TDATA_W    = 8;

    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST  = DEBOUNCE_W'(50);
    localparam logic [HOLD_TICKS_W-1:0] LONG_RST      = HOLD_TICKS_W'(4000);
    localparam logic [HOLD_TICKS_W-1:0] VERY_LONG_RST = HOLD_TICKS_W'(10000);
    localparam logic                    ACTIVE_LOW_RST = 1'b1;
    localparam logic                    IDLE_LEVEL     = 1'b1;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG       = 2'd1,
        REG_VERY_LONG  = 2'd2,
        REG_ACTIVE_LOW = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic edge_seen;
        logic press_start;
        logic pressed;
    } t_deb_status;

    typedef struct packed {
        logic very_long_event;
        logic long_event;
    } t_hold_events;

    typedef struct packed {
        logic very_long_event;
        logic long_event;
        logic is_pressed;
        logic edge_seen;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/bdlp_debounce.sv */
// Raw level tracking, saturating settle counter and stable level acceptance.
// Depends on bdlp_pkg.
`default_nettype none
module bdlp_debounce import bdlp_pkg::*; #(
    parameter int SETTLE_COUNT_BITS = SETTLE_COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_level,
    input  wire logic [DEBOUNCE_W-1:0] i_debounce_ticks,
    input  wire logic                  i_active_low,
    output t_deb_status                o_status,
    output logic                       o_stable_level
);

    localparam int CMP_W = (SETTLE_COUNT_BITS > DEBOUNCE_W) ? SETTLE_COUNT_BITS : DEBOUNCE_W;

    logic                         r_raw_last, n_raw_last;
    logic                         r_stable, n_stable;
    logic [SETTLE_COUNT_BITS-1:0] r_settle, n_settle;
    logic                         accept;

    always_comb begin
        n_raw_last = i_level;
        if (i_level != r_raw_last) begin
            n_settle = '0;
        end else if (r_settle != '1) begin
            n_settle = r_settle + 1'b1;
        end else begin
            n_settle = r_settle;
        end
        accept   = (CMP_W'(n_settle) > CMP_W'(i_debounce_ticks)) && (i_level != r_stable);
        n_stable = accept ? i_level : r_stable;

        o_status.edge_seen   = accept;
        o_status.press_start = accept && (i_level ^ i_active_low);
        o_status.pressed     = n_stable ^ i_active_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_last <= IDLE_LEVEL;
            r_stable   <= IDLE_LEVEL;
            r_settle   <= '0;
        end else if (i_step) begin
            r_raw_last <= n_raw_last;
            r_stable   <= n_stable;
            r_settle   <= n_settle;
        end
    end

    assign o_stable_level = r_stable;

endmodule
`default_nettype wire

/* hw/rtl/bdlp_hold.sv */
// Saturating hold timer with once-per-press long and very long events.
// Depends on bdlp_pkg.
`default_nettype none
module bdlp_hold import bdlp_pkg::*; #(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire t_deb_status             i_status,
    input  wire logic [HOLD_TICKS_W-1:0] i_long_ticks,
    input  wire logic [HOLD_TICKS_W-1:0] i_very_long_ticks,
    output t_hold_events                 o_events
);

    localparam int CMP_W = (HOLD_COUNT_BITS > HOLD_TICKS_W) ? HOLD_COUNT_BITS : HOLD_TICKS_W;

    logic [HOLD_COUNT_BITS-1:0] r_hold, n_hold;
    logic                       r_active, n_active;
    logic                       r_long_done, n_long_done;
    logic                       r_very_done, n_very_done;

    always_comb begin
        n_hold      = (r_active && (r_hold != '1)) ? r_hold + 1'b1 : r_hold;
        n_active    = r_active;
        n_long_done = r_long_done;
        n_very_done = r_very_done;
        o_events    = '0;

        if (i_status.press_start) begin
            n_hold      = '0;
            n_active    = 1'b1;
            n_long_done = 1'b0;
            n_very_done = 1'b0;
        end

        if (i_status.pressed && n_active) begin
            if (!n_very_done && (CMP_W'(n_hold) >= CMP_W'(i_very_long_ticks))) begin
                n_very_done              = 1'b1;
                o_events.very_long_event = 1'b1;
            end else if (!n_long_done && (CMP_W'(n_hold) >= CMP_W'(i_long_ticks))) begin
                n_long_done         = 1'b1;
                o_events.long_event = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_active    <= 1'b0;
            r_long_done <= 1'b0;
            r_very_done <= 1'b0;
        end else if (i_step) begin
            r_hold      <= n_hold;
            r_active    <= n_active;
            r_long_done <= n_long_done;
            r_very_done <= n_very_done;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/button_debounce_long_press.sv */
// Button debouncer with long and very long press detection, top level.
// Each accepted input word loads its result word into the output register.
// Throughput: one word per cycle while the output is not stalled; state updates and the result register load on accept.
// Reset (synchronous, active low): registers to defaults, idle level, counters cleared.
// Depends on bdlp_pkg, bdlp_debounce and bdlp_hold.
`default_nettype none
module button_debounce_long_press import bdlp_pkg::*; #(
    parameter int HOLD_COUNT_BITS   = HOLD_COUNT_BITS_DEF,
    parameter int SETTLE_COUNT_BITS = SETTLE_COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,   // [0] pin_level

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,   // [0] edge_seen, [1] is_pressed,
                                                       // [2] long_event, [3] very_long_event

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [DEBOUNCE_W-1:0]   r_debounce_ticks;
    logic [HOLD_TICKS_W-1:0] r_long_ticks;
    logic [HOLD_TICKS_W-1:0] r_very_long_ticks;
    logic                    r_active_low;

    logic                    r_out_valid;
    t_result                 r_out;

    t_reg_idx                reg_idx;
    logic                    cfg_wr;
    logic                    step;
    t_deb_status             deb_status;
    t_hold_events            events;
    logic                    stable_level;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks  <= DEBOUNCE_RST;
            r_long_ticks      <= LONG_RST;
            r_very_long_ticks <= VERY_LONG_RST;
            r_active_low      <= ACTIVE_LOW_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DEBOUNCE:   r_debounce_ticks  <= pwdata[DEBOUNCE_W-1:0];
                REG_LONG:       r_long_ticks      <= pwdata[HOLD_TICKS_W-1:0];
                REG_VERY_LONG:  r_very_long_ticks <= pwdata[HOLD_TICKS_W-1:0];
                REG_ACTIVE_LOW: r_active_low      <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = APB_DATA_W'(r_debounce_ticks);
            REG_LONG:       prdata = APB_DATA_W'(r_long_ticks);
            REG_VERY_LONG:  prdata = APB_DATA_W'(r_very_long_ticks);
            REG_ACTIVE_LOW: prdata = APB_DATA_W'(r_active_low);
        endcase
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    bdlp_debounce #(
        .SETTLE_COUNT_BITS (SETTLE_COUNT_BITS)
    ) u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_level          (s_axis_tdata[0]),
        .i_debounce_ticks (r_debounce_ticks),
        .i_active_low     (r_active_low),
        .o_status         (deb_status),
        .o_stable_level   (stable_level)
    );

    bdlp_hold #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_hold (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_status          (deb_status),
        .i_long_ticks      (r_long_ticks),
        .i_very_long_ticks (r_very_long_ticks),
        .o_events          (events)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.edge_seen       <= deb_status.edge_seen;
            r_out.is_pressed      <= deb_status.pressed;
            r_out.long_event      <= events.long_event;
            r_out.very_long_event <= events.very_long_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.long_event && r_out.very_long_event))
        else $error("long and very long events fired together");

    a_event_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.long_event || r_out.very_long_event) |-> r_out.is_pressed)
        else $error("press event reported while released");

    a_edge_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && deb_status.edge_seen |=> stable_level != $past(stable_level))
        else $error("edge reported without stable level change");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule
`default_nettype wire
